/* hw/rtl/disk_sweep_scheduler_defines.svh */
// ---------------------------------------------------------------------------
// Disk sweep scheduler assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef DISK_SWEEP_SCHEDULER_DEFINES_SVH
`define DISK_SWEEP_SCHEDULER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("disk_sweep_scheduler: property violated");

// antecedent implies consequent in the next cycle
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("disk_sweep_scheduler: property violated");

`endif

/* hw/rtl/dss_pkg.sv */
// ---------------------------------------------------------------------------
// dss_pkg
// Types and constants shared by the disk sweep scheduler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_BITS     = 12;
  localparam int TOTAL_W      = 18;
  localparam int CNT_W        = CYL_BITS + 1;
  localparam int IDX_W        = $clog2(MAX_REQUESTS + 1);
  localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_POSITION  = 2'd2;

  localparam logic       MODE_RST  = 1'b1;
  localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(200);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DOWN,
    S_UP,
    S_LOW,
    S_TO_ZERO,
    S_TO_LAST
  } state_t;

  typedef enum logic [1:0] {
    TSEL_STORE,
    TSEL_ZERO,
    TSEL_LAST
  } tsel_t;

  typedef struct packed {
    logic             insert;
    logic             load;
    logic             emit;
    logic             final_mv;
    logic             clear;
    tsel_t            tsel;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] count;
    logic             ge_head;
    logic             mode;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/dss_ctrl.sv */
// ---------------------------------------------------------------------------
// dss_ctrl
// Sequencer: head slot search, then the sweep passes of SCAN or C-SCAN.
// ---------------------------------------------------------------------------
`default_nettype none

module dss_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         last_request,
  input  wire dss_pkg::sts_t sts,
  output dss_pkg::cmd_t     cmd,
  output logic              busy
);
  import dss_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic             hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      pos   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pos   <= pos_next;
    end
  end

  assign busy = (state != S_IDLE);
  // first stored entry at or above the head, or the end of the store
  assign hit  = (idx == sts.count) || sts.ge_head;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    pos_next     = pos;
    cmd          = '0;
    cmd.tsel     = TSEL_STORE;
    cmd.idx      = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.insert = 1'b1;
          if (last_request) begin
            state_next = S_SEARCH;
            idx_next   = '0;
          end
        end
      end
      S_SEARCH: begin
        cmd.load = 1'b1;
        if (hit) begin
          pos_next = idx;
          if (!sts.mode) begin
            if (idx == '0) begin
              state_next = S_TO_ZERO;
            end else begin
              state_next = S_DOWN;
              idx_next   = idx - IDX_W'(1);
            end
          end else begin
            state_next = (idx == sts.count) ? S_TO_LAST : S_UP;
          end
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_DOWN: begin
        cmd.emit = 1'b1;
        if (idx == '0) begin
          state_next = S_TO_ZERO;
        end else begin
          idx_next = idx - IDX_W'(1);
        end
      end
      S_TO_ZERO: begin
        cmd.emit = 1'b1;
        cmd.tsel = TSEL_ZERO;
        if (!sts.mode) begin
          if (pos == sts.count) begin
            state_next = S_TO_LAST;
          end else begin
            state_next = S_UP;
            idx_next   = pos;
          end
        end else if (pos == '0) begin
          cmd.final_mv = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_LOW;
          idx_next   = '0;
        end
      end
      S_UP: begin
        cmd.emit = 1'b1;
        if ((idx + IDX_W'(1)) == sts.count) begin
          state_next = S_TO_LAST;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_TO_LAST: begin
        cmd.emit = 1'b1;
        cmd.tsel = TSEL_LAST;
        if (!sts.mode) begin
          cmd.final_mv = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_TO_ZERO;
        end
      end
      S_LOW: begin
        cmd.emit = 1'b1;
        if ((idx + IDX_W'(1)) == pos) begin
          cmd.final_mv = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/dss_datapath.sv */
// ---------------------------------------------------------------------------
// dss_datapath
// Config registers, sorted request store, head compare and movement output.
// ---------------------------------------------------------------------------
`default_nettype none

module dss_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dss_pkg::cmd_t                 cmd,
  output dss_pkg::sts_t                      sts,
  input  wire logic                          cfg_valid,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dss_pkg::CNT_W-1:0]     cfg_data,
  input  wire logic [dss_pkg::CYL_BITS-1:0]  request_cylinder,
  output logic                               result_strobe,
  output logic [dss_pkg::CYL_BITS-1:0]       from_cylinder,
  output logic [dss_pkg::CYL_BITS-1:0]       to_cylinder,
  output logic [dss_pkg::CYL_BITS-1:0]       move_distance,
  output logic [dss_pkg::TOTAL_W-1:0]        running_total,
  output logic                               final_move
);
  import dss_pkg::*;

  localparam logic [CYL_BITS-1:0] CYL_MAX = '1;

  logic                sweep_mode;
  logic [CNT_W-1:0]    cylinder_count;
  logic [CYL_BITS-1:0] head_position;

  logic [CYL_BITS-1:0] store      [MAX_REQUESTS];
  logic [CYL_BITS-1:0] store_next [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] le;
  logic [IDX_W-1:0]    count;

  logic [CNT_W-1:0]    cnt_dec;
  logic [CYL_BITS-1:0] lastc;
  logic [CYL_BITS-1:0] head_c;
  logic [CYL_BITS-1:0] rd, rd_c;
  logic [CYL_BITS-1:0] target;
  logic [CYL_BITS-1:0] cur;
  logic [CYL_BITS-1:0] move_dist;
  logic [TOTAL_W-1:0]  total;

  // configuration, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode     <= MODE_RST;
      cylinder_count <= COUNT_RST;
      head_position  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SWEEP_MODE:     sweep_mode     <= cfg_data[0];
        CFG_CYLINDER_COUNT: cylinder_count <= cfg_data;
        CFG_HEAD_POSITION:  head_position  <= cfg_data[CYL_BITS-1:0];
        default:            ;
      endcase
    end
  end

  // last cylinder, saturated to the cylinder field range
  always_comb begin
    cnt_dec = (cylinder_count == '0) ? '0 : cylinder_count - CNT_W'(1);
    lastc   = (cnt_dec > CNT_W'(CYL_MAX)) ? CYL_MAX : cnt_dec[CYL_BITS-1:0];
    head_c  = (head_position > lastc) ? lastc : head_position;
  end

  // insertion: each slot keeps, takes the request, or takes its lower neighbor
  always_comb begin
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      le[i] = (IDX_W'(i) < count) && (store[i] <= request_cylinder);
    end
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      if (le[i]) begin
        store_next[i] = store[i];
      end else if (i == 0) begin
        store_next[i] = request_cylinder;
      end else if (le[i-1]) begin
        store_next[i] = request_cylinder;
      end else begin
        store_next[i] = store[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && (count < IDX_W'(MAX_REQUESTS))) begin
      store <= store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.insert && (count < IDX_W'(MAX_REQUESTS))) begin
      count <= count + IDX_W'(1);
    end
  end

  // single read port, clamped at read time (clamping keeps the order)
  always_comb begin
    rd   = store[cmd.idx[ADDR_W-1:0]];
    rd_c = (rd > lastc) ? lastc : rd;
    unique case (cmd.tsel)
      TSEL_STORE: target = rd_c;
      TSEL_ZERO:  target = '0;
      TSEL_LAST:  target = lastc;
      default:    target = '0;
    endcase
    move_dist = (cur > target) ? cur - target : target - cur;
  end

  assign sts.count   = count;
  assign sts.ge_head = (rd_c >= head_c);
  assign sts.mode    = sweep_mode;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= head_c;
      total <= '0;
    end else if (cmd.emit) begin
      cur   <= target;
      total <= total + TOTAL_W'(move_dist);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      from_cylinder <= cur;
      to_cylinder   <= target;
      move_distance <= move_dist;
      running_total <= total + TOTAL_W'(move_dist);
      final_move    <= cmd.final_mv;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/disk_sweep_scheduler.sv */
// ---------------------------------------------------------------------------
// disk_sweep_scheduler
// SCAN / C-SCAN seek scheduler over a batch of cylinder requests.
// ---------------------------------------------------------------------------
// Usage:
//   Requests: drive request_cylinder and last_request with start high; the
//   request is taken on an edge where busy is low. A request that is not last
//   is sorted into the store in that cycle and busy stays low, so one request
//   per cycle is accepted. Requests beyond the store depth are dropped.
//   Last request: busy rises. The head slot search walks the store one entry
//   per cycle, then the N+2 movements for N held requests come out one per
//   cycle on result_strobe, final_move on the last one. After the search, the
//   first movement is emitted by the first sweep state and registered onto
//   the result outputs; the one read port of the store sets the
//   one-movement-per-cycle pace. busy falls with the final movement and the
//   store is empty again. Results are shown for one cycle only; the receiver
//   cannot stall. Config: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   ready is always high. Write only while busy is low and no result is pending.
//   Reset (rst, synchronous): store empty, mode C-SCAN, 200 cylinders, head 0.
// ---------------------------------------------------------------------------
`default_nettype none

module disk_sweep_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dss_pkg::CYL_BITS-1:0]  request_cylinder,
  input  wire logic                          last_request,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dss_pkg::CNT_W-1:0]     cfg_data,
  output logic                               result_strobe,
  output logic [dss_pkg::CYL_BITS-1:0]       from_cylinder,
  output logic [dss_pkg::CYL_BITS-1:0]       to_cylinder,
  output logic [dss_pkg::CYL_BITS-1:0]       move_distance,
  output logic [dss_pkg::TOTAL_W-1:0]        running_total,
  output logic                               final_move
);
  import dss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  dss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_request (last_request),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  dss_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .request_cylinder (request_cylinder),
    .result_strobe    (result_strobe),
    .from_cylinder    (from_cylinder),
    .to_cylinder      (to_cylinder),
    .move_distance    (move_distance),
    .running_total    (running_total),
    .final_move       (final_move)
  );

endmodule

`default_nettype wire

/* hw/rtl/dss_checker.sv */
// ---------------------------------------------------------------------------
// dss_checker
// Port-level checks on the movement stream of the scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

`include "disk_sweep_scheduler_defines.svh"

module dss_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         busy,
  input wire logic                         result_strobe,
  input wire logic [dss_pkg::CYL_BITS-1:0] from_cylinder,
  input wire logic [dss_pkg::CYL_BITS-1:0] to_cylinder,
  input wire logic                         final_move
);

  // a schedule is a gapless burst
  `DSS_ASSERT_NEXT(a_burst_gapless, result_strobe && !final_move, result_strobe)
  // nothing directly after the final movement
  `DSS_ASSERT_NEXT(a_gap_after_final, result_strobe && final_move, !result_strobe)
  // a non-final movement only while the scheduler is busy
  `DSS_ASSERT_SAME(a_busy_in_burst, result_strobe && !final_move, busy)
  // movements chain: each starts where the previous one ended
  `DSS_ASSERT_NEXT(a_chain, result_strobe && !final_move,
                   from_cylinder == $past(to_cylinder))

endmodule

bind disk_sweep_scheduler dss_checker u_dss_checker (.*);

`default_nettype wire
